FILE: hdl/arbb_pkg.sv
// Shared types and constants for the affine rectangle bounding box block.
// Holds the payload structs, the register map and the register reset values.
// Depends on nothing.
package arbb_pkg;

  localparam int DataW   = 32;
  localparam int AddrW   = 5;
  localparam int IdxW    = 3;
  localparam int NumRegs = 6;

  localparam logic [IdxW-1:0] REG_COEF_A   = 3'd0;
  localparam logic [IdxW-1:0] REG_COEF_B   = 3'd1;
  localparam logic [IdxW-1:0] REG_COEF_C   = 3'd2;
  localparam logic [IdxW-1:0] REG_COEF_D   = 3'd3;
  localparam logic [IdxW-1:0] REG_OFFSET_X = 3'd4;
  localparam logic [IdxW-1:0] REG_OFFSET_Y = 3'd5;

  localparam logic signed [DataW-1:0] RST_COEF_A   = 32'sd65536;
  localparam logic signed [DataW-1:0] RST_COEF_B   = 32'sd0;
  localparam logic signed [DataW-1:0] RST_COEF_C   = 32'sd0;
  localparam logic signed [DataW-1:0] RST_COEF_D   = 32'sd65536;
  localparam logic signed [DataW-1:0] RST_OFFSET_X = 32'sd0;
  localparam logic signed [DataW-1:0] RST_OFFSET_Y = 32'sd0;

  typedef struct packed {
    logic signed [DataW-1:0] x_first;
    logic signed [DataW-1:0] x_second;
    logic signed [DataW-1:0] y_first;
    logic signed [DataW-1:0] y_second;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] min_x;
    logic signed [DataW-1:0] max_x;
    logic signed [DataW-1:0] min_y;
    logic signed [DataW-1:0] max_y;
  } out_item_t;

endpackage

FILE: hdl/affine_rect_bounding_box_core.sv
// The block takes one rectangle transfer per cycle while in_ready_o is high and returns one
// bounding box transfer for each; an output stall can hold the input. The five register
// stages are the eight 32 by 32 products, the corner sums with rounding, the offset add with
// saturation, and two levels of min and max selection. Stalls hold only blocked stages; bubbles
// inside the pipeline are still filled while the output waits. The six matrix registers sit
// behind an APB port with pready tied high and must only be written while the pipeline is empty.
// Depends on arbb_pkg.
module affine_rect_bounding_box_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  arbb_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output arbb_pkg::out_item_t               out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [arbb_pkg::AddrW-1:0]        paddr,
  input  logic [arbb_pkg::DataW-1:0]        pwdata,
  output logic [arbb_pkg::DataW-1:0]        prdata,
  output logic                              pready
);
  import arbb_pkg::*;

  localparam int NumStages = 5;
  localparam int ProdW     = 2 * DataW;
  localparam int SumW      = ProdW + 1;
  localparam int ShW       = SumW - FRAC_BITS;
  localparam int TW        = ShW + 1;
  localparam logic signed [SumW-1:0] Half = SumW'(1) << (FRAC_BITS - 1);

  logic signed [DataW-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
  logic signed [DataW-1:0] offset_x_q, offset_y_q;
  logic [IdxW-1:0]         reg_idx;
  logic                    cfg_wr;

  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q   <= RST_COEF_A;
      coef_b_q   <= RST_COEF_B;
      coef_c_q   <= RST_COEF_C;
      coef_d_q   <= RST_COEF_D;
      offset_x_q <= RST_OFFSET_X;
      offset_y_q <= RST_OFFSET_Y;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COEF_A:   coef_a_q   <= pwdata;
        REG_COEF_B:   coef_b_q   <= pwdata;
        REG_COEF_C:   coef_c_q   <= pwdata;
        REG_COEF_D:   coef_d_q   <= pwdata;
        REG_OFFSET_X: offset_x_q <= pwdata;
        REG_OFFSET_Y: offset_y_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COEF_A:   prdata = coef_a_q;
      REG_COEF_B:   prdata = coef_b_q;
      REG_COEF_C:   prdata = coef_c_q;
      REG_COEF_D:   prdata = coef_d_q;
      REG_OFFSET_X: prdata = offset_x_q;
      REG_OFFSET_Y: prdata = offset_y_q;
      default:      prdata = '0;
    endcase
  end

  // Pipeline control: a stage loads when it is empty or its contents move on.
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStages-1];

  // Stage 0: products of each edge with its two matrix terms.
  logic signed [ProdW-1:0] ax_d[2], cy_d[2], bx_d[2], dy_d[2];
  logic signed [ProdW-1:0] ax_q[2], cy_q[2], bx_q[2], dy_q[2];

  always_comb begin
    ax_d[0] = coef_a_q * in_data_i.x_first;
    ax_d[1] = coef_a_q * in_data_i.x_second;
    bx_d[0] = coef_b_q * in_data_i.x_first;
    bx_d[1] = coef_b_q * in_data_i.x_second;
    cy_d[0] = coef_c_q * in_data_i.y_first;
    cy_d[1] = coef_c_q * in_data_i.y_second;
    dy_d[0] = coef_d_q * in_data_i.y_first;
    dy_d[1] = coef_d_q * in_data_i.y_second;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ax_q <= ax_d;
      bx_q <= bx_d;
      cy_q <= cy_d;
      dy_q <= dy_d;
    end
  end

  // Stage 1: corner sums with the rounding constant. Corner k uses x edge k/2, y edge k%2.
  logic signed [SumW-1:0] sx_d[4], sy_d[4], sx_q[4], sy_q[4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sx_d[k] = SumW'(ax_q[k/2]) + SumW'(cy_q[k%2]) + Half;
      sy_d[k] = SumW'(bx_q[k/2]) + SumW'(dy_q[k%2]) + Half;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
  end

  // Stage 2: drop the fraction, add the offset and saturate to the output range.
  logic signed [TW-1:0]    tx[4], ty[4];
  logic signed [DataW-1:0] cx_d[4], cy2_d[4], cx_q[4], cy2_q[4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tx[k] = TW'(signed'(sx_q[k][SumW-1:FRAC_BITS])) + TW'(offset_x_q);
      ty[k] = TW'(signed'(sy_q[k][SumW-1:FRAC_BITS])) + TW'(offset_y_q);
      if ((&tx[k][TW-1:DataW-1]) || !(|tx[k][TW-1:DataW-1])) begin
        cx_d[k] = tx[k][DataW-1:0];
      end else begin
        cx_d[k] = tx[k][TW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      end
      if ((&ty[k][TW-1:DataW-1]) || !(|ty[k][TW-1:DataW-1])) begin
        cy2_d[k] = ty[k][DataW-1:0];
      end else begin
        cy2_d[k] = ty[k][TW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      cx_q  <= cx_d;
      cy2_q <= cy2_d;
    end
  end

  // Stage 3: min and max within each pair of corners.
  logic signed [DataW-1:0] lox_d[2], hix_d[2], loy_d[2], hiy_d[2];
  logic signed [DataW-1:0] lox_q[2], hix_q[2], loy_q[2], hiy_q[2];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      lox_d[p] = (cx_q[2*p] < cx_q[2*p+1]) ? cx_q[2*p] : cx_q[2*p+1];
      hix_d[p] = (cx_q[2*p] > cx_q[2*p+1]) ? cx_q[2*p] : cx_q[2*p+1];
      loy_d[p] = (cy2_q[2*p] < cy2_q[2*p+1]) ? cy2_q[2*p] : cy2_q[2*p+1];
      hiy_d[p] = (cy2_q[2*p] > cy2_q[2*p+1]) ? cy2_q[2*p] : cy2_q[2*p+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      lox_q <= lox_d;
      hix_q <= hix_d;
      loy_q <= loy_d;
      hiy_q <= hiy_d;
    end
  end

  // Stage 4: final selection into the output register.
  out_item_t out_d, out_q;

  always_comb begin
    out_d.min_x = (lox_q[0] < lox_q[1]) ? lox_q[0] : lox_q[1];
    out_d.max_x = (hix_q[0] > hix_q[1]) ? hix_q[0] : hix_q[1];
    out_d.min_y = (loy_q[0] < loy_q[1]) ? loy_q[0] : loy_q[1];
    out_d.max_y = (hiy_q[0] > hiy_q[1]) ? hiy_q[0] : hiy_q[1];
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: hdl/arbb_checker.sv
// Port-level assertions for the affine rectangle bounding box block and the bind that
// attaches them to its top level.
// Depends on arbb_pkg and affine_rect_bounding_box_core.
module arbb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input arbb_pkg::out_item_t        out_data_o,
  input logic                       psel,
  input logic                       pwrite,
  input logic                       penable,
  input logic [arbb_pkg::AddrW-1:0] paddr,
  input logic [arbb_pkg::DataW-1:0] pwdata,
  input logic [arbb_pkg::DataW-1:0] prdata
);
  import arbb_pkg::*;

  // A stalled result transfer keeps its box.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // Every box is ordered on both axes.
  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.min_x <= out_data_o.max_x) &&
                    (out_data_o.min_y <= out_data_o.max_y))
    else $error("bounding box has min above max");

  // With no result waiting, the pipeline always has room for a new transfer.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while output is empty");

  // A register read right after a write to it returns the written data.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr[AddrW-1:2] < IdxW'(NumRegs))) ##1
    (psel && !pwrite && (paddr == $past(paddr))) |-> prdata == $past(pwdata))
    else $error("register readback mismatch");

endmodule

bind affine_rect_bounding_box_core arbb_checker u_arbb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .pwrite      (pwrite),
  .penable     (penable),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

FILE: dv/affine_rect_bounding_box_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for affine_rect_bounding_box_core: directed rectangles,
// then randomized ones under randomly chosen matrices, with random stalls on both sides.
// Depends on arbb_pkg and the core itself.
module affine_rect_bounding_box_core_test;
  import arbb_pkg::*;

  localparam int FracBits   = 16;
  localparam int CycleLimit = 500000;
  localparam int AddrSlots  = 1 << IdxW;
  localparam int RandPhases = 7;
  localparam int PhaseItems = 200;
  localparam int NumRows    = 21;

  typedef enum int {VAL_TINY, VAL_SMALL, VAL_FULL, VAL_EDGE} val_kind_e;
  typedef enum logic [2:0] {CFG_RESET, CFG_ALL_MAX, CFG_ALL_MIN, CFG_ROTATE, CFG_HALF} cfg_id_e;
  typedef logic [DataW-1:0] reg_set_t [NumRegs];

  typedef struct packed {
    cfg_id_e   cfg;
    logic      fixed;
    in_item_t  rect;
    out_item_t box;
  } dir_row_t;

  typedef struct packed {
    logic      fixed;
    out_item_t box;
  } fixed_box_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready_o;
  in_item_t          in_data;
  logic              out_valid_o;
  logic              out_ready;
  out_item_t         out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  reg_set_t   matrix;
  fixed_box_t fixed_boxes[$];
  out_item_t  expected_boxes[$];
  fixed_box_t fb;
  out_item_t  want;
  int         mismatch_count;
  int         cycle_count;
  int         send_gap_max;
  int         recv_gap_max;
  int         hold_cycles;

  reg_set_t cfg_sets [5] = '{
    '{RST_COEF_A, RST_COEF_B, RST_COEF_C, RST_COEF_D, RST_OFFSET_X, RST_OFFSET_Y},
    '{6{32'h7FFFFFFF}},
    '{6{32'h80000000}},
    '{32'h00000000, 32'h00010000, 32'hFFFF0000, 32'h00000000, 32'h00100000, 32'hFFF00000},
    '{32'h00008000, 32'hFFFF8000, 32'h00000001, 32'h00008000, 32'h00000000, 32'h00000000}
  };

  dir_row_t dir_rows [NumRows] = '{
    {CFG_RESET, 1'b1, {32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
                      {32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000}},
    {CFG_RESET, 1'b1, {32'h00010000, 32'hFFFF0000, 32'h00030000, 32'h00020000},
                      {32'hFFFF0000, 32'h00010000, 32'h00020000, 32'h00030000}},
    {CFG_RESET, 1'b1, {32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF},
                      {32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF}},
    {CFG_RESET, 1'b1, {32'h00003039, 32'h00003039, 32'hFFFFFCF7, 32'hFFFFFCF7},
                      {32'h00003039, 32'h00003039, 32'hFFFFFCF7, 32'hFFFFFCF7}},
    {CFG_RESET, 1'b1, {32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
                      {32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}},
    {CFG_ALL_MAX, 1'b1, {32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
                        {32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}},
    {CFG_ALL_MAX, 1'b1, {32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF},
                        {32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF}},
    {CFG_ALL_MAX, 1'b0, {32'h00000001, 32'hFFFFFFFF, 32'h00000002, 32'hFFFFFFFE}, 128'd0},
    {CFG_ALL_MAX, 1'b0, {32'hFFF00000, 32'h00100000, 32'h00000000, 32'h00000000}, 128'd0},
    {CFG_ALL_MIN, 1'b1, {32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
                        {32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000}},
    {CFG_ALL_MIN, 1'b1, {32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000},
                        {32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}},
    {CFG_ALL_MIN, 1'b0, {32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 128'd0},
    {CFG_ALL_MIN, 1'b0, {32'h00010000, 32'h00000000, 32'h00000000, 32'h00010000}, 128'd0},
    {CFG_ROTATE, 1'b0, {32'h00010000, 32'h00050000, 32'h00020000, 32'hFFFE0000}, 128'd0},
    {CFG_ROTATE, 1'b0, {32'h00008000, 32'h00008000, 32'h00004000, 32'h00004000}, 128'd0},
    {CFG_ROTATE, 1'b0, {32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h00000000}, 128'd0},
    {CFG_HALF, 1'b0, {32'h00000001, 32'hFFFFFFFF, 32'h00000000, 32'h00000000}, 128'd0},
    {CFG_HALF, 1'b0, {32'h00000003, 32'hFFFFFFFD, 32'h00000001, 32'hFFFFFFFF}, 128'd0},
    {CFG_HALF, 1'b0, {32'h00000005, 32'h00000007, 32'h00000000, 32'h00000000}, 128'd0},
    {CFG_HALF, 1'b0, {32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000}, 128'd0},
    {CFG_HALF, 1'b0, {32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0}, 128'd0}
  };

  affine_rect_bounding_box_core #(
    .FRAC_BITS(FracBits)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk = ~clk;

  function automatic logic signed [DataW-1:0] map_coord(
    input logic signed [DataW-1:0] p,
    input logic signed [DataW-1:0] x,
    input logic signed [DataW-1:0] q,
    input logic signed [DataW-1:0] y,
    input logic signed [DataW-1:0] off
  );
    logic signed [65:0] pw, xw, qw, yw, ow, acc;
    pw = p;
    xw = x;
    qw = q;
    yw = y;
    ow = off;
    acc = pw * xw + qw * yw + (66'sd1 <<< (FracBits - 1));
    acc = (acc >>> FracBits) + ow;
    if (acc > 66'sd2147483647) return {1'b0, {(DataW-1){1'b1}}};
    if (acc < -66'sd2147483648) return {1'b1, {(DataW-1){1'b0}}};
    return acc[DataW-1:0];
  endfunction

  function automatic out_item_t predict_box(input in_item_t r);
    logic signed [DataW-1:0] xs [2];
    logic signed [DataW-1:0] ys [2];
    logic signed [DataW-1:0] tx, ty;
    out_item_t b;
    xs[0] = r.x_first;
    xs[1] = r.x_second;
    ys[0] = r.y_first;
    ys[1] = r.y_second;
    b = '0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        tx = map_coord(matrix[REG_COEF_A], xs[i], matrix[REG_COEF_C], ys[j],
                       matrix[REG_OFFSET_X]);
        ty = map_coord(matrix[REG_COEF_B], xs[i], matrix[REG_COEF_D], ys[j],
                       matrix[REG_OFFSET_Y]);
        if (i == 0 && j == 0) begin
          b = {tx, tx, ty, ty};
        end else begin
          if (tx < b.min_x) b.min_x = tx;
          if (tx > b.max_x) b.max_x = tx;
          if (ty < b.min_y) b.min_y = ty;
          if (ty > b.max_y) b.max_y = ty;
        end
      end
    end
    return b;
  endfunction

  function automatic val_kind_e pick_kind();
    return val_kind_e'($urandom_range(0, 3));
  endfunction

  function automatic logic [DataW-1:0] rand_word(input val_kind_e k);
    int v;
    case (k)
      VAL_TINY:  v = int'($urandom_range(0, 512)) - 256;
      VAL_SMALL: v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      VAL_FULL:  v = $urandom;
      default: begin
        case ($urandom_range(0, 6))
          0:       v = 32'h7FFFFFFF;
          1:       v = 32'h80000000;
          2:       v = 0;
          3:       v = -1;
          4:       v = 1;
          5:       v = 65536;
          default: v = -65536;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic note_mismatch(input string what, input logic [DataW-1:0] got,
                               input logic [DataW-1:0] exp_val);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, exp_val);
    mismatch_count++;
  endtask

  task automatic send_rect(input in_item_t r, input logic fixed, input out_item_t box);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    fixed_boxes.push_back({fixed, box});
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready_o);
    @(negedge clk);
  endtask

  task automatic drain_boxes();
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [IdxW-1:0] idx,
                            input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && idx < NumRegs) matrix[idx] = wdata;
    @(negedge clk);
  endtask

  task automatic program_regs(input reg_set_t vals);
    logic [DataW-1:0] rd;
    drain_boxes();
    for (int i = 0; i < NumRegs; i++) apb_access(1'b1, IdxW'(i), vals[i], rd);
    // Writes to unmapped slots must leave the matrix alone.
    for (int i = NumRegs; i < AddrSlots; i++) apb_access(1'b1, IdxW'(i), $urandom, rd);
    for (int i = 0; i < NumRegs; i++) begin
      apb_access(1'b0, IdxW'(i), '0, rd);
      if (rd !== matrix[i]) note_mismatch($sformatf("register %0d readback", i), rd, matrix[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        if (expected_boxes.size() == 0) begin
          note_mismatch("box transfer with none pending", out_data_o.min_x, '0);
        end else begin
          want = expected_boxes.pop_front();
          if (out_data_o.min_x !== want.min_x) note_mismatch("min_x", out_data_o.min_x, want.min_x);
          if (out_data_o.max_x !== want.max_x) note_mismatch("max_x", out_data_o.max_x, want.max_x);
          if (out_data_o.min_y !== want.min_y) note_mismatch("min_y", out_data_o.min_y, want.min_y);
          if (out_data_o.max_y !== want.max_y) note_mismatch("max_y", out_data_o.max_y, want.max_y);
        end
      end
      if (in_valid && in_ready_o) begin
        fb = fixed_boxes.pop_front();
        expected_boxes.push_back(fb.fixed ? fb.box : predict_box(in_data));
      end
    end
  end

  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, recv_gap_max);
      if (hold_cycles != 0 || gap != 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles + gap) @(negedge clk);
        hold_cycles = 0;
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid_o);
      @(negedge clk);
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    cfg_id_e  cur_cfg;
    reg_set_t vals;
    in_item_t r;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_gap_max   = 9;
    recv_gap_max   = 9;
    hold_cycles    = 0;
    matrix         = cfg_sets[CFG_RESET];
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cur_cfg = CFG_RESET;
    for (int n = 0; n < NumRows; n++) begin
      if (dir_rows[n].cfg != cur_cfg) begin
        cur_cfg = dir_rows[n].cfg;
        program_regs(cfg_sets[cur_cfg]);
      end
      send_rect(dir_rows[n].rect, dir_rows[n].fixed, dir_rows[n].box);
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      for (int i = 0; i < NumRegs; i++) vals[i] = rand_word(pick_kind());
      program_regs(vals);
      send_gap_max = (ph == 1) ? 0 : 9;
      recv_gap_max = (ph == 1) ? 0 : 9;
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 3 && n == 20) begin
          hold_cycles  = 300;
          send_gap_max = 0;
        end
        if (ph == 3 && n == 80) send_gap_max = 9;
        if (ph == 5 && n == 100) drain_boxes();
        r.x_first  = rand_word(pick_kind());
        r.x_second = ($urandom_range(0, 6) == 0) ? r.x_first : rand_word(pick_kind());
        r.y_first  = rand_word(pick_kind());
        r.y_second = ($urandom_range(0, 6) == 0) ? r.y_first : rand_word(pick_kind());
        send_rect(r, 1'b0, '0);
      end
    end

    drain_boxes();
    if (mismatch_count == 0 && expected_boxes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
